/* sv/cpp_pkg.sv */
// Shared types, widths and register codes for the cylinder point partition block.
package cpp_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIR_BITS   = 18;
	localparam int FRAC       = 16;
	localparam int D_W        = COORD_BITS + 1;
	localparam int P1_W       = D_W + DIR_BITS;
	localparam int T1_W       = P1_W - FRAC;
	localparam int DP_W       = T1_W + 2;
	localparam int P2_W       = DP_W + DIR_BITS;
	localparam int T2_W       = P2_W - FRAC;
	localparam int E_W        = T2_W + 1;
	localparam int MAG_W      = 32;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int RAD_W      = 64;
	localparam int APB_AW     = 6;
	localparam int APB_DW     = 64;
	localparam int IDX_W      = APB_AW - 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIR_BITS-1:0]   dir_t;
	typedef logic signed [D_W-1:0]        d_t;
	typedef logic signed [P1_W-1:0]       p1_t;
	typedef logic signed [DP_W-1:0]       dp_t;
	typedef logic signed [P2_W-1:0]       p2_t;
	typedef logic [IDX_W-1:0]             reg_idx_t;

	localparam p1_t RND1 = p1_t'(1) <<< (FRAC - 1);
	localparam p2_t RND2 = p2_t'(1) <<< (FRAC - 1);

	localparam reg_idx_t REG_LINE_X    = 3'd0;
	localparam reg_idx_t REG_LINE_Y    = 3'd1;
	localparam reg_idx_t REG_LINE_Z    = 3'd2;
	localparam reg_idx_t REG_DIR_X     = 3'd3;
	localparam reg_idx_t REG_DIR_Y     = 3'd4;
	localparam reg_idx_t REG_DIR_Z     = 3'd5;
	localparam reg_idx_t REG_RADIUS_SQ = 3'd6;

	typedef struct packed {
		coord_t           line_x;
		coord_t           line_y;
		coord_t           line_z;
		dir_t             dir_x;
		dir_t             dir_y;
		dir_t             dir_z;
		logic [RAD_W-1:0] radius_sq;
	} cfg_t;

	// Item leaving the projection half: offset from the axis point and its projection.
	typedef struct packed {
		logic vld;
		logic ok;
		d_t   d0;
		d_t   d1;
		d_t   d2;
		p2_t  q0;
		p2_t  q1;
		p2_t  q2;
	} proj_t;

endpackage

/* sv/cpp_if.sv */
// Valid/ready channel interfaces for points in and test results out.
interface cpp_pt_if import cpp_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t px;
	coord_t py;
	coord_t pz;
	logic   valid_in;

	modport source (output valid, output px, output py, output pz, output valid_in,
		input ready);
	modport sink (input valid, input px, input py, input pz, input valid_in,
		output ready);
endinterface

interface cpp_res_if ();
	logic valid;
	logic ready;
	logic valid_out;

	modport source (output valid, output valid_out, input ready);
	modport sink (input valid, input valid_out, output ready);
endinterface

/* sv/cpp_cfg.sv */
// APB register file holding the cylinder axis, direction and squared radius.
module cpp_cfg import cpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[APB_AW-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_LINE_X:    cfg_q.line_x    <= pwdata[COORD_BITS-1:0];
				REG_LINE_Y:    cfg_q.line_y    <= pwdata[COORD_BITS-1:0];
				REG_LINE_Z:    cfg_q.line_z    <= pwdata[COORD_BITS-1:0];
				REG_DIR_X:     cfg_q.dir_x     <= pwdata[DIR_BITS-1:0];
				REG_DIR_Y:     cfg_q.dir_y     <= pwdata[DIR_BITS-1:0];
				REG_DIR_Z:     cfg_q.dir_z     <= pwdata[DIR_BITS-1:0];
				REG_RADIUS_SQ: cfg_q.radius_sq <= pwdata[RAD_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LINE_X:    prdata = APB_DW'(unsigned'(cfg_q.line_x));
			REG_LINE_Y:    prdata = APB_DW'(unsigned'(cfg_q.line_y));
			REG_LINE_Z:    prdata = APB_DW'(unsigned'(cfg_q.line_z));
			REG_DIR_X:     prdata = APB_DW'(unsigned'(cfg_q.dir_x));
			REG_DIR_Y:     prdata = APB_DW'(unsigned'(cfg_q.dir_y));
			REG_DIR_Z:     prdata = APB_DW'(unsigned'(cfg_q.dir_z));
			REG_RADIUS_SQ: prdata = APB_DW'(cfg_q.radius_sq);
			default:       prdata = '0;
		endcase
	end

endmodule

/* sv/cpp_proj.sv */
// Stages 1-4: offset from the axis point, dot product with the axis, projection products.
module cpp_proj import cpp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld,
	input  logic   ok,
	input  coord_t px,
	input  coord_t py,
	input  coord_t pz,
	input  cfg_t   cfg,
	output proj_t  prj
);

	coord_t pt_c   [3];
	coord_t line_c [3];
	dir_t   dir_c  [3];
	logic signed [T1_W-1:0] t1_c [3];
	p1_t    r1_c   [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	d_t   d_s1 [3];
	d_t   d_s2 [3];
	d_t   d_s3 [3];
	d_t   d_s4 [3];
	p1_t  p_s2 [3];
	dp_t  dp_s3;
	p2_t  q_s4 [3];

	always_comb begin
		pt_c[0]   = px;
		pt_c[1]   = py;
		pt_c[2]   = pz;
		line_c[0] = cfg.line_x;
		line_c[1] = cfg.line_y;
		line_c[2] = cfg.line_z;
		dir_c[0]  = cfg.dir_x;
		dir_c[1]  = cfg.dir_y;
		dir_c[2]  = cfg.dir_z;
		for (int i = 0; i < 3; i++) begin
			r1_c[i] = p_s2[i] + RND1;
			t1_c[i] = r1_c[i][P1_W-1:FRAC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= ok;
			ok_s2 <= ok_s1;
			ok_s3 <= ok_s2;
			ok_s4 <= ok_s3;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= D_W'(pt_c[i]) - D_W'(line_c[i]);
				p_s2[i] <= P1_W'(d_s1[i]) * P1_W'(dir_c[i]);
				d_s2[i] <= d_s1[i];
				d_s3[i] <= d_s2[i];
				q_s4[i] <= P2_W'(dp_s3) * P2_W'(dir_c[i]);
				d_s4[i] <= d_s3[i];
			end
			dp_s3 <= DP_W'(t1_c[0]) + DP_W'(t1_c[1]) + DP_W'(t1_c[2]);
		end
	end

	always_comb begin
		prj.vld = vld_s4;
		prj.ok  = ok_s4;
		prj.d0  = d_s4[0];
		prj.d1  = d_s4[1];
		prj.d2  = d_s4[2];
		prj.q0  = q_s4[0];
		prj.q1  = q_s4[1];
		prj.q2  = q_s4[2];
	end

endmodule

/* sv/cpp_dist.sv */
// Stages 5-7: residual vector, saturating squares, saturating sum and radius compare.
module cpp_dist import cpp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  proj_t            prj,
	input  logic [RAD_W-1:0] radius_sq,
	output logic             vld,
	output logic             in_cyl
);

	d_t   d_c [3];
	p2_t  q_c [3];
	p2_t  r2_c [3];
	logic signed [T2_W-1:0] t2_c [3];
	logic signed [E_W-1:0]  e_c  [3];
	logic [E_W-1:0]         m_c  [3];
	logic [SQ_W+1:0]        sum_c;
	logic                   sat_c;
	logic [SQ_W-1:0]        r_c;

	logic vld_s5, vld_s6, vld_s7;
	logic ok_s5, ok_s6;
	logic [MAG_W-1:0] mag_s5 [3];
	logic             big_s5 [3];
	logic [SQ_W-1:0]  sq_s6  [3];
	logic             big_s6 [3];
	logic             in_s7;

	always_comb begin
		d_c[0] = prj.d0;
		d_c[1] = prj.d1;
		d_c[2] = prj.d2;
		q_c[0] = prj.q0;
		q_c[1] = prj.q1;
		q_c[2] = prj.q2;
		for (int i = 0; i < 3; i++) begin
			r2_c[i] = q_c[i] + RND2;
			t2_c[i] = r2_c[i][P2_W-1:FRAC];
			e_c[i]  = E_W'(d_c[i]) - E_W'(t2_c[i]);
			m_c[i]  = e_c[i][E_W-1] ? E_W'(-e_c[i]) : E_W'(e_c[i]);
		end
		sum_c = (SQ_W+2)'(sq_s6[0]) + (SQ_W+2)'(sq_s6[1]) + (SQ_W+2)'(sq_s6[2]);
		sat_c = big_s6[0] || big_s6[1] || big_s6[2] || (|sum_c[SQ_W+1:SQ_W]);
		r_c   = sat_c ? '1 : sum_c[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s5 <= prj.vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= prj.ok;
			ok_s6 <= ok_s5;
			for (int i = 0; i < 3; i++) begin
				mag_s5[i] <= m_c[i][MAG_W-1:0];
				big_s5[i] <= |m_c[i][E_W-1:MAG_W];
				sq_s6[i]  <= SQ_W'(mag_s5[i]) * SQ_W'(mag_s5[i]);
				big_s6[i] <= big_s5[i];
			end
			in_s7 <= ok_s6 && !(r_c > radius_sq);
		end
	end

	assign vld    = vld_s7;
	assign in_cyl = in_s7;

endmodule

/* sv/cylinder_point_partition.sv */
// Top level of the infinite-cylinder point test pipeline.
// Each point item is tested against an infinite cylinder whose axis runs through
// (line_x, line_y, line_z) along (dir_x, dir_y, dir_z); the direction is taken as
// written, not normalized. The block forms d = p - line, dp = d.dir (each term
// rounded half up back to Q16.16), e = d - dp*dir (same rounding), and the squared
// distance |e|^2 with saturation at 2^64-1; valid_out is valid_in and that distance
// not above radius_sq. A point that arrives invalid always leaves with valid_out low.
// Throughput is one item per clock while the output is not stalled; there are seven
// register stages, the last being the output register: four stages of offset, dot
// product and projection multiplies, then residual, square and sum-and-compare
// stages. The pipe advances as a whole whenever the output register is empty or
// being taken, so a stalled result holds every stage in place and the input is
// refused for that cycle.
// Registers sit on an APB port at byte address 8*index: line_x, line_y, line_z,
// dir_x, dir_y, dir_z, radius_sq; write them only while no item is in flight.
module cylinder_point_partition import cpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	cpp_pt_if.sink            pt,
	cpp_res_if.source         res
);

	cfg_t  cfg;
	proj_t prj;
	logic  en;
	logic  res_vld;
	logic  res_in;

	// Advance the whole pipe when the output register is free or drains this cycle.
	assign en       = !res_vld || res.ready;
	assign pt.ready = en;

	cpp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Offset and projection: a bubble enters when no item is offered.
	cpp_proj u_proj (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (pt.valid),
		.ok     (pt.valid_in),
		.px     (pt.px),
		.py     (pt.py),
		.pz     (pt.pz),
		.cfg    (cfg),
		.prj    (prj)
	);

	// Residual, squared distance and the radius compare; last stage is the output register.
	cpp_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.prj       (prj),
		.radius_sq (cfg.radius_sq),
		.vld       (res_vld),
		.in_cyl    (res_in)
	);

	assign res.valid     = res_vld;
	assign res.valid_out = res_in;

endmodule
